@@ rtl/core/binary_erosion_3x3_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 binary erosion block
// Clocked on aclk; the gated form is switched off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef BINARY_EROSION_3X3_ASSERT_SVH
`define BINARY_EROSION_3X3_ASSERT_SVH
`ifndef SYNTH
`define BE3_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define BE3_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define BE3_ASSERT(lbl, prop, msg)
`define BE3_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/core/be3_pkg.sv @@
// ----------------------------------------------------------------------------
// be3_pkg
// Shared types and constants for the 3x3 binary erosion block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package be3_pkg;

    localparam int IDX_W      = 18;
    localparam int CNT_W      = $clog2(IDX_W + 1);
    localparam int THR_W      = 8;
    localparam int IMG_W      = 10;
    localparam int MASK_W     = 9;
    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WIDTH     = 2'd1,
        CFG_HEIGHT    = 2'd2,
        CFG_MASK      = 2'd3
    } cfg_reg_t;

    localparam logic [THR_W-1:0]  THRESHOLD_RST = 8'd120;
    localparam logic [IMG_W-1:0]  IMG_SIZE_RST  = 10'd374;
    localparam logic [MASK_W-1:0] MASK_RST      = 9'd186;

    localparam logic [PIX_W-1:0]  PIX_FG   = 8'd255;
    localparam logic [PIX_W-1:0]  PIX_BG   = 8'd0;

    // window columns shift right; new column enters at bits 2, 5, 8
    localparam logic [MASK_W-1:0] WIN_KEEP = 9'h0DB;

    localparam logic REQ_FLUSH = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

@@ rtl/core/be3_line_store.sv @@
// ----------------------------------------------------------------------------
// be3_line_store
// Two line stores of binarised pixels in one 2-bit wide memory, with
// registered read and write-to-read bypass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module be3_line_store #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [1:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [1:0]    rd_data
);

    logic [1:0] mem [DEPTH];
    logic [1:0] rd_data_reg;
    logic [1:0] wr_data_reg;
    logic       bypass_reg;
    logic       bypass_next;

    assign bypass_next = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        wr_data_reg <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bypass_reg <= 1'b0;
        end else begin
            bypass_reg <= bypass_next;
        end
    end

    assign rd_data = bypass_reg ? wr_data_reg : rd_data_reg;

endmodule

@@ rtl/core/be3_pos_div.sv @@
// ----------------------------------------------------------------------------
// be3_pos_div
// Restoring divider, one quotient bit per cycle: splits the output index
// into row and column after the row width changes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "binary_erosion_3x3_assert.svh"

module be3_pos_div import be3_pkg::*; #(
    parameter int DIV_W = 10
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [IDX_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic [IDX_W-1:0] quotient,
    output logic [DIV_W-1:0] remainder,
    output div_status_t      status
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } div_state_t;

    div_state_t       state_reg, state_next;
    logic             done_reg, done_next;
    logic [IDX_W-1:0] dq_reg, dq_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] divisor_reg, divisor_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [DIV_W:0]   rem_shift;
    logic [DIV_W:0]   rem_sub;
    logic             fits;
    logic [DIV_W-1:0] rem_step;

    assign rem_shift = {rem_reg, dq_reg[IDX_W-1]};
    assign fits      = rem_shift >= {1'b0, divisor_reg};
    assign rem_sub   = rem_shift - {1'b0, divisor_reg};
    assign rem_step  = fits ? rem_sub[DIV_W-1:0] : rem_shift[DIV_W-1:0];

    always_comb begin
        state_next   = state_reg;
        done_next    = 1'b0;
        dq_next      = dq_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        count_next   = count_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next   = ST_RUN;
                    dq_next      = dividend;
                    rem_next     = '0;
                    divisor_next = divisor;
                    count_next   = CNT_W'(IDX_W - 1);
                end
            end
            ST_RUN: begin
                dq_next    = {dq_reg[IDX_W-2:0], fits};
                rem_next   = rem_step;
                count_next = count_reg - 1'b1;
                if (count_reg == '0) begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        dq_reg      <= dq_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        count_reg   <= count_next;
    end

    assign quotient    = dq_reg;
    assign remainder   = rem_reg;
    assign status.busy = (state_reg == ST_RUN) || done_reg;
    assign status.done = done_reg;

    `BE3_ASSERT(a_div_rem_below_divisor, done_reg |-> (rem_reg < divisor_reg), "remainder not below divisor")
    `BE3_ASSERT(a_div_busy_from_start, $rose(status.busy) |-> $past(start), "divider started unasked")
    `BE3_ASSERT_ALWAYS(a_div_idle_after_reset, !aresetn |=> !status.busy, "divider busy after reset")

endmodule

@@ rtl/core/binary_erosion_3x3.sv @@
// ----------------------------------------------------------------------------
// binary_erosion_3x3
// Streaming 3x3 binary erosion: threshold, two line stores, window test.
// ----------------------------------------------------------------------------
// Takes one item per clock unless the output stalls or the divider is busy.
// A pixel item is thresholded and shifted into the 3x3 window; once one row
// plus one pixel has arrived each pixel item yields one result, 255 on the
// one-pixel border and the masked window test inside. After the last pixel,
// any further item, flush or pixel, drains one remaining result; the final
// result of a frame carries m_frame_last and the counters restart. A result
// sits in the output register the cycle after its item is taken, and the
// next item is taken in the same cycle it is read out. The line stores are
// one memory read a column ahead, so they add no stall. Writing image_width
// holds off both input and configuration while an 18-step divider re-derives
// the output row and column from the output index for the new width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "binary_erosion_3x3_assert.svh"

module binary_erosion_3x3 import be3_pkg::*; #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_req_type,
    input  logic [PIX_W-1:0]      s_pixel_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIX_W-1:0]      m_out_pixel,
    output logic                  m_frame_last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int W_W   = $clog2(MAX_WIDTH + 1);
    localparam int H_W   = $clog2(MAX_HEIGHT + 1);
    localparam int CWW   = (W_W > IMG_W) ? W_W : IMG_W;
    localparam int CHW   = (H_W > IMG_W) ? H_W : IMG_W;
    localparam int CMP_W = IDX_W + 1;

    localparam logic [CMP_W-1:0] ONE_X = CMP_W'(1);
    localparam logic [CMP_W-1:0] TWO_X = CMP_W'(2);

    // configuration
    logic [THR_W-1:0]  thr_reg, thr_next;
    logic [IMG_W-1:0]  width_reg, width_next;
    logic [IMG_W-1:0]  height_reg, height_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic              div_start_reg, div_start_next;

    // counters and window
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [H_W-1:0]    in_row_reg, in_row_next;
    logic [MASK_W-1:0] win_reg, win_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic [IDX_W-1:0]  out_row_reg, out_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [PIX_W-1:0]  pix_reg, pix_next;
    logic              last_reg, last_next;

    logic [W_W-1:0]    eff_w;
    logic [H_W-1:0]    eff_h;
    logic [CMP_W-1:0]  ow, oh, irow_x, icol_x, orow_x, ocol_x;

    logic              accept, cfg_accept, input_done, is_flush, cur;
    logic              do_pixel, do_emit, pix_emit, col_wrap, frame_end, interior, hit;
    logic [MASK_W-1:0] win_upd;
    logic [PIX_W-1:0]  pix_out;
    logic [1:0]        ls_rd;

    logic [IDX_W-1:0]  div_quo;
    logic [W_W-1:0]    div_rem;
    div_status_t       div_st;

    // clamp geometry to 1..MAX
    always_comb begin
        if (width_reg == '0) begin
            eff_w = W_W'(1);
        end else if (CWW'(width_reg) > CWW'(MAX_WIDTH)) begin
            eff_w = W_W'(MAX_WIDTH);
        end else begin
            eff_w = W_W'(width_reg);
        end
        if (height_reg == '0) begin
            eff_h = H_W'(1);
        end else if (CHW'(height_reg) > CHW'(MAX_HEIGHT)) begin
            eff_h = H_W'(MAX_HEIGHT);
        end else begin
            eff_h = H_W'(height_reg);
        end
    end

    assign ow     = CMP_W'(eff_w);
    assign oh     = CMP_W'(eff_h);
    assign irow_x = CMP_W'(in_row_reg);
    assign icol_x = CMP_W'(in_col_reg);
    assign orow_x = CMP_W'(out_row_reg);
    assign ocol_x = CMP_W'(out_col_reg);

    assign cfg_ready  = !div_start_reg && !div_st.busy;
    assign s_ready    = !div_start_reg && !div_st.busy && (!m_valid_reg || m_ready);
    assign accept     = s_valid && s_ready;
    assign cfg_accept = cfg_valid && cfg_ready;

    assign input_done = irow_x >= oh;
    assign is_flush   = s_req_type == REQ_FLUSH;
    assign cur        = s_pixel_value > thr_reg;

    assign win_upd = ((win_reg >> 1) & WIN_KEEP)
                   | {cur, 2'b00, ls_rd[0], 2'b00, ls_rd[1], 2'b00};

    assign col_wrap = (icol_x + ONE_X) >= ow;
    assign pix_emit = (irow_x >= TWO_X)
                   || ((irow_x == ONE_X) && (icol_x >= ONE_X))
                   || ((irow_x == '0) && (icol_x >= ow + ONE_X));

    assign do_pixel = accept && !input_done && !is_flush;
    assign do_emit  = accept && (input_done || (!is_flush && pix_emit));

    assign frame_end = (orow_x >= oh) || (((orow_x + ONE_X) == oh) && ((ocol_x + ONE_X) == ow));
    assign interior  = !input_done && (orow_x >= ONE_X) && ((orow_x + ONE_X) < oh)
                    && (ocol_x >= ONE_X) && ((ocol_x + ONE_X) < ow);
    assign hit       = (win_upd & mask_reg) == mask_reg;
    assign pix_out   = (interior && !hit) ? PIX_BG : PIX_FG;

    always_comb begin
        thr_next       = thr_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        mask_next      = mask_reg;
        div_start_next = 1'b0;
        if (cfg_accept) begin
            case (cfg_index)
                CFG_THRESHOLD: thr_next = cfg_data[THR_W-1:0];
                CFG_WIDTH: begin
                    width_next     = cfg_data[IMG_W-1:0];
                    div_start_next = 1'b1;
                end
                CFG_HEIGHT:    height_next = cfg_data[IMG_W-1:0];
                CFG_MASK:      mask_next = cfg_data[MASK_W-1:0];
                default:       thr_next = thr_reg;
            endcase
        end
    end

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        win_next     = win_reg;
        out_idx_next = out_idx_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (do_pixel) begin
            win_next = win_upd;
            if (col_wrap) begin
                in_col_next = '0;
                in_row_next = in_row_reg + 1'b1;
            end else begin
                in_col_next = in_col_reg + 1'b1;
            end
        end
        if (do_emit) begin
            if (frame_end) begin
                out_idx_next = '0;
                out_row_next = '0;
                out_col_next = '0;
                in_row_next  = '0;
                in_col_next  = '0;
                win_next     = '0;
            end else begin
                out_idx_next = out_idx_reg + 1'b1;
                if ((ocol_x + ONE_X) >= ow) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end else begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end
        if (div_st.done) begin
            out_row_next = div_quo;
            out_col_next = COL_W'(div_rem);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        pix_next     = pix_reg;
        last_next    = last_reg;
        if (do_emit) begin
            m_valid_next = 1'b1;
            pix_next     = pix_out;
            last_next    = frame_end;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg       <= THRESHOLD_RST;
            width_reg     <= IMG_SIZE_RST;
            height_reg    <= IMG_SIZE_RST;
            mask_reg      <= MASK_RST;
            div_start_reg <= 1'b0;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            win_reg       <= '0;
            out_idx_reg   <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            thr_reg       <= thr_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            mask_reg      <= mask_next;
            div_start_reg <= div_start_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            win_reg       <= win_next;
            out_idx_reg   <= out_idx_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pix_reg  <= pix_next;
        last_reg <= last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_pixel  = pix_reg;
    assign m_frame_last = last_reg;

    // upper row in bit 1, middle row in bit 0; read one column ahead
    be3_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W)
    ) u_line_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (do_pixel),
        .wr_addr (in_col_reg),
        .wr_data ({ls_rd[0], cur}),
        .rd_addr (in_col_next),
        .rd_data (ls_rd)
    );

    be3_pos_div #(
        .DIV_W (W_W)
    ) u_pos_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start_reg),
        .dividend  (out_idx_reg),
        .divisor   (eff_w),
        .quotient  (div_quo),
        .remainder (div_rem),
        .status    (div_st)
    );

    `BE3_ASSERT(a_frame_restart, (do_emit && frame_end) |=> ((out_idx_reg == '0) && (in_row_reg == '0) && (win_reg == '0)), "counters not restarted at frame end")
    `BE3_ASSERT(a_out_col_in_row, !(div_start_reg || div_st.busy) |-> (ocol_x < ow), "output column beyond row width")
    `BE3_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable({pix_reg, last_reg}), "item dropped")

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for binary_erosion_3x3
// Streams grey frames through the eroder with random gaps and stalls on both
// channels, re-predicts every result with an in-bench erosion model (line
// stores, 3x3 window, border rule, drain and frame restart) and compares each
// result against it in order.
// ----------------------------------------------------------------------------

module tb;
    import be3_pkg::*;

    localparam logic REQ_PIXEL = ~REQ_FLUSH;
    localparam int   LINE_MAX  = 512;
    localparam int   ROWS_MAX  = 512;

    typedef struct {
        logic             req;
        logic [PIX_W-1:0] value;
    } stream_item_t;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             last;
    } eroded_px_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_req_type = 1'b0;
    logic [PIX_W-1:0]      s_pixel_value = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [PIX_W-1:0]      m_out_pixel;
    logic                  m_frame_last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_reg_t              cfg_index = CFG_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    binary_erosion_3x3 dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_pixel_value (s_pixel_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_pixel   (m_out_pixel),
        .m_frame_last  (m_frame_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    // register shadows
    logic [THR_W-1:0]  thr_reg  = THRESHOLD_RST;
    logic [IMG_W-1:0]  wid_reg  = IMG_SIZE_RST;
    logic [IMG_W-1:0]  hgt_reg  = IMG_SIZE_RST;
    logic [MASK_W-1:0] mask_reg = MASK_RST;

    // erosion model state
    bit                upper_line [LINE_MAX];
    bit                middle_line[LINE_MAX];
    logic [MASK_W-1:0] erode_win = '0;
    int                col_in    = 0;
    int                row_in    = 0;
    int                out_pos   = 0;

    stream_item_t stream_q[$];
    eroded_px_t   eroded_q[$];
    stream_item_t nxt_item;
    eroded_px_t   want;

    bit idle_free = 1'b0;
    int error_count = 0;
    int items_pushed = 0;
    int items_taken = 0;
    int results_seen = 0;
    int frames_done = 0;

    function automatic int line_len();
        if (wid_reg < 1) return 1;
        if (wid_reg > LINE_MAX) return LINE_MAX;
        return wid_reg;
    endfunction

    function automatic int frame_rows();
        if (hgt_reg < 1) return 1;
        if (hgt_reg > ROWS_MAX) return ROWS_MAX;
        return hgt_reg;
    endfunction

    function automatic void emit_eroded(bit from_win);
        int         w;
        int         h;
        int         orow;
        int         ocol;
        eroded_px_t r;
        w = line_len();
        h = frame_rows();
        orow = out_pos / w;
        ocol = out_pos % w;
        r.pix = PIX_FG;
        if (from_win && orow >= 1 && orow + 1 < h && ocol >= 1 && ocol + 1 < w) begin
            r.pix = ((erode_win & mask_reg) == mask_reg) ? PIX_FG : PIX_BG;
        end
        if (out_pos + 1 >= w * h) begin
            r.last = 1'b1;
            out_pos = 0;
            row_in = 0;
            col_in = 0;
            erode_win = '0;
        end else begin
            r.last = 1'b0;
            out_pos = out_pos + 1;
        end
        eroded_q.push_back(r);
    endfunction

    function automatic void erode_step(logic req, logic [PIX_W-1:0] value);
        int w;
        int h;
        int pos;
        int idx;
        bit cur;
        bit top;
        bit mid;
        w = line_len();
        h = frame_rows();
        if (row_in >= h) begin
            emit_eroded(1'b0);
            return;
        end
        if (req == REQ_FLUSH) return;
        pos = row_in * w + col_in;
        idx = col_in % LINE_MAX;
        cur = value > thr_reg;
        top = upper_line[idx];
        mid = middle_line[idx];
        upper_line[idx] = mid;
        middle_line[idx] = cur;
        erode_win = ((erode_win >> 1) & WIN_KEEP)
                  | (MASK_W'(top) << 2) | (MASK_W'(mid) << 5) | (MASK_W'(cur) << 8);
        if (col_in + 1 >= w) begin
            col_in = 0;
            row_in = row_in + 1;
        end else begin
            col_in = col_in + 1;
        end
        if (pos >= w + 1) emit_eroded(1'b1);
    endfunction

    task automatic report_mismatch(string what);
        error_count++;
        $display("ERROR @%0t: %s", $time, what);
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                erode_step(s_req_type, s_pixel_value);
                items_taken++;
            end
            if (!s_valid || s_ready) begin
                if (stream_q.size() > 0 && (idle_free || $urandom_range(99) >= 37)) begin
                    nxt_item = stream_q.pop_front();
                    s_valid <= 1'b1;
                    s_req_type <= nxt_item.req;
                    s_pixel_value <= nxt_item.value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (eroded_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected item: pixel %0d last %0b",
                                              m_out_pixel, m_frame_last));
                end else begin
                    want = eroded_q.pop_front();
                    if (m_out_pixel !== want.pix)
                        report_mismatch($sformatf("result %0d: pixel %0d, want %0d",
                                                  results_seen, m_out_pixel, want.pix));
                    if (m_frame_last !== want.last)
                        report_mismatch($sformatf("result %0d: frame_last %0b, want %0b",
                                                  results_seen, m_frame_last, want.last));
                    if (want.last) frames_done++;
                end
            end
            m_ready <= idle_free || $urandom_range(99) >= 37;
        end
    end

    function automatic void push_item(logic req, logic [PIX_W-1:0] value);
        stream_item_t it;
        it.req = req;
        it.value = value;
        stream_q.push_back(it);
        items_pushed++;
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        if ($urandom_range(7) == 0) return PIX_W'($urandom_range(255));
        if ($urandom_range(3) != 0) begin
            if (thr_reg == 8'd255) return 8'd255;
            return PIX_W'($urandom_range(255, thr_reg + 1));
        end
        return PIX_W'($urandom_range(thr_reg, 0));
    endfunction

    task automatic wait_drained();
        @(negedge aclk);
        while (stream_q.size() != 0 || s_valid || eroded_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic set_config(int thr, int wd, int ht, int msk);
        cfg_reg_t              regs[4];
        logic [CFG_DATA_W-1:0] vals[4];
        int                    k;
        regs = '{CFG_THRESHOLD, CFG_WIDTH, CFG_HEIGHT, CFG_MASK};
        vals = '{CFG_DATA_W'(thr), CFG_DATA_W'(wd), CFG_DATA_W'(ht), CFG_DATA_W'(msk)};
        // let any last pixel still in flight settle
        repeat (30) @(posedge aclk);
        cfg_valid <= 1'b1;
        for (k = 0; k < 4; k++) begin
            cfg_index <= regs[k];
            cfg_data <= vals[k];
            do @(posedge aclk); while (!cfg_ready);
            case (regs[k])
                CFG_THRESHOLD: thr_reg = vals[k][THR_W-1:0];
                CFG_WIDTH:     wid_reg = vals[k][IMG_W-1:0];
                CFG_HEIGHT:    hgt_reg = vals[k][IMG_W-1:0];
                CFG_MASK:      mask_reg = vals[k][MASK_W-1:0];
                default:       ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // one whole frame: pixels with stray flushes, then the drain
    task automatic run_frame(bit pause_mid);
        int npx;
        int ndrain;
        int i;
        npx = line_len() * frame_rows();
        ndrain = (npx >= line_len() + 1) ? line_len() + 1 : npx;
        if ($urandom_range(7) == 0) push_item(REQ_FLUSH, PIX_W'($urandom));
        for (i = 0; i < npx; i++) begin
            if ($urandom_range(15) == 0) push_item(REQ_FLUSH, PIX_W'($urandom));
            push_item(REQ_PIXEL, pick_pixel());
            if (pause_mid && i == npx / 2) wait_drained();
        end
        for (i = 0; i < ndrain; i++) begin
            if ($urandom_range(2) == 0) push_item(REQ_PIXEL, PIX_W'($urandom));
            else push_item(REQ_FLUSH, PIX_W'($urandom));
        end
        wait_drained();
    endtask

    function automatic int pick_threshold();
        case ($urandom_range(7))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    function automatic int pick_mask();
        case ($urandom_range(7))
            0:       return 0;
            1:       return 511;
            2:       return MASK_RST;
            default: return $urandom_range(511);
        endcase
    endfunction

    initial begin
        int  i;
        int  frames_run;
        bit  big_done;
        frames_run = 0;
        big_done = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // 1x1 frame: leading flush, one pixel, pixel-as-flush, stray flush
        set_config(0, 1, 1, 0);
        push_item(REQ_FLUSH, 8'hA5);
        push_item(REQ_PIXEL, 8'd0);
        push_item(REQ_PIXEL, 8'd255);
        push_item(REQ_FLUSH, 8'h5A);
        wait_drained();

        // 3x3 full mask, centre pixel just at threshold
        set_config(254, 3, 3, 511);
        for (i = 0; i < 9; i++) push_item(REQ_PIXEL, (i == 4) ? 8'd254 : 8'd255);
        push_item(REQ_FLUSH, 8'd0);
        push_item(REQ_PIXEL, 8'd0);
        push_item(REQ_FLUSH, 8'd255);
        push_item(REQ_PIXEL, 8'd255);
        wait_drained();

        while (items_pushed < 1400) begin
            if (!big_done && items_pushed > 500) begin
                // width clamps up to one, height down to the maximum, no gaps anywhere
                idle_free = 1'b1;
                set_config(pick_threshold(), 0, 1023, pick_mask());
                run_frame(1'b0);
                idle_free = 1'b0;
                big_done = 1'b1;
            end
            if ($urandom_range(9) == 0)
                set_config(pick_threshold(), $urandom_range(2), $urandom_range(3),
                           pick_mask());
            else
                set_config(pick_threshold(), $urandom_range(12, 1), $urandom_range(8, 0),
                           pick_mask());
            run_frame(frames_run % 4 == 0);
            frames_run++;
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("Streamed %0d items over %0d frames, %0d eroded pixels checked",
                 items_taken, frames_done, results_seen);
        $display("Frames from 1x1 up to 12-pixel lines plus a 512-row column, all masks");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
